[rtl/gics_pkg.sv]
package gics_pkg;

  // internal fraction bits
  localparam int QF = 28;

  // ln 2 in Q30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // rational approximation coefficients, Q28
  localparam logic [29:0] C0 = 30'd675253953;
  localparam logic [29:0] C1 = 30'd215514211;
  localparam logic [29:0] C2 = 30'd2772401;
  localparam logic [29:0] D0 = 30'd384611100;
  localparam logic [29:0] D1 = 30'd50806510;
  localparam logic [29:0] D2 = 30'd351114;

  localparam int UNIFORM_BITS_DEF = 32;

  // register indexes
  localparam logic CFG_MEAN = 1'b0;
  localparam logic CFG_STD  = 1'b1;

  localparam logic [31:0] MEAN_RST = 32'h0000_0000;
  localparam logic [31:0] STD_RST  = 32'h0001_0000;

endpackage

[rtl/gaussian_inverse_cdf_sampler.sv]
// Gaussian sampler by inverse normal CDF. Each transaction on the input side takes a
// UNIFORM_BITS-bit uniform word U (zero is treated as the smallest step) and returns one
// sample mean + sigma * z in signed Q16.16, where z comes from the three-term rational
// approximation applied to t = sqrt(-2 ln min(U, 1-U)). A new word may be started every
// clock cycle; busy is never raised. The result appears on out_* for a single cycle with
// out_valid high, after the fold, log2, square-root, polynomial, divider and scaling
// stages. The receiver cannot stall the block, so results must be taken when
// strobed. The latency is set by the bit-per-stage square root (T_W stages), the
// bit-per-stage divider (Q_W stages) and one stage per squaring of the log2 mantissa.
// out_saturated flags a sample clipped to the 32-bit range. mean and std_dev may only
// be rewritten while no transaction is in flight.
module gaussian_inverse_cdf_sampler import gics_pkg::*; #(
  parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [UNIFORM_BITS-1:0] in_uniform_fraction,
  output logic                    out_valid,
  output logic signed [31:0]      out_sample_value,
  output logic                    out_saturated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_data
);

  localparam int UB     = UNIFORM_BITS;
  localparam int KW     = $clog2(UB);
  localparam int NW     = UB + 31;
  localparam int LG_W   = $clog2(UB + 1) + QF;
  localparam int Y_W    = LG_W + 1;
  localparam int RAD_W  = Y_W + QF;
  localparam int T_W    = (RAD_W + 1) / 2;
  localparam int NUM_W  = T_W + 3;
  localparam int Q_W    = NUM_W;
  localparam int DEN_W  = 2 * T_W - 26;
  localparam int Z_W    = Q_W + 1;
  localparam int P_W    = Q_W + 32;
  localparam int MAG_W  = Q_W + 5;
  localparam int TOT_W  = Q_W + 7;
  localparam int LAT    = QF + 10 + T_W + Q_W;

  // stage numbers (register outputs)
  localparam int S_Y    = QF + 2;
  localparam int S_RT   = S_Y + T_W;
  localparam int S_DV   = S_RT + 4 + Q_W;
  localparam int S_Z    = S_DV + 1;

  localparam logic [T_W-1:0] C0T = T_W'(C0);
  localparam logic [T_W-1:0] C1T = T_W'(C1);
  localparam logic [T_W-1:0] C2T = T_W'(C2);
  localparam logic [T_W-1:0] D0T = T_W'(D0);
  localparam logic [T_W-1:0] D1T = T_W'(D1);
  localparam logic [T_W-1:0] D2T = T_W'(D2);

  localparam logic signed [TOT_W-1:0] SMAX = TOT_W'(64'sd2147483647);
  localparam logic signed [TOT_W-1:0] SMIN = -TOT_W'(64'sd2147483648);

  // ---------------------------------------------------------------------------
  // configuration and handshake
  // ---------------------------------------------------------------------------
  logic [31:0] mean_r;
  logic [31:0] std_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= MEAN_RST;
      std_r  <= STD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MEAN: mean_r <= cfg_data;
        CFG_STD:  std_r  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // valid and half-select bits travel alongside the datapath
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] low_r;
  logic           lower_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    low_r <= {low_r[LAT-2:0], lower_in};
  end

  // ---------------------------------------------------------------------------
  // stage 0: fold the upper half onto the lower, clamp zero
  // ---------------------------------------------------------------------------
  logic [UB-1:0] u_c;
  logic [UB-1:0] x_r;

  always_comb begin
    u_c      = (in_uniform_fraction == '0) ? UB'(1) : in_uniform_fraction;
    lower_in = !u_c[UB-1];
  end

  always_ff @(posedge clk) begin
    x_r <= lower_in ? u_c : ({UB{1'b0}} - u_c);
  end

  // ---------------------------------------------------------------------------
  // stage 1: leading-one position and Q30 mantissa
  // ---------------------------------------------------------------------------
  logic [KW-1:0] k_c;
  logic [NW-1:0] norm_c;

  always_comb begin
    k_c = '0;
    for (int i = 0; i < UB; i++) begin
      if (x_r[i]) k_c = KW'(i);
    end
    norm_c = {x_r, 31'b0} << (KW'(UB - 1) - k_c);
  end

  logic [30:0]   sq_m_r    [0:QF];
  logic [QF-1:0] sq_frac_r [0:QF];
  logic [KW-1:0] sq_k_r    [0:QF];

  always_ff @(posedge clk) begin
    sq_m_r[0]    <= norm_c[NW-1 -: 31];
    sq_frac_r[0] <= '0;
    sq_k_r[0]    <= k_c;
  end

  // one squaring per stage, one fraction bit each
  for (genvar i = 0; i < QF; i++) begin : g_sq
    logic [61:0] sqr;
    logic [31:0] s32;

    always_comb begin
      sqr = sq_m_r[i] * sq_m_r[i];
      s32 = sqr[61:30];
    end

    always_ff @(posedge clk) begin
      sq_m_r[i+1]    <= s32[31] ? s32[31:1] : s32[30:0];
      sq_frac_r[i+1] <= {sq_frac_r[i][QF-2:0], s32[31]};
      sq_k_r[i+1]    <= sq_k_r[i];
    end
  end

  // ---------------------------------------------------------------------------
  // -2 ln p = 2 ln2 * (-log2 p), then the radicand y << QF
  // ---------------------------------------------------------------------------
  logic [LG_W-1:0]      lg_c;
  logic [LG_W+29:0]     lgp_c;
  logic [2*T_W-1:0]     rt_rad_r  [0:T_W];
  logic [T_W+1:0]       rt_rem_r  [0:T_W];
  logic [T_W-1:0]       rt_root_r [0:T_W];

  always_comb begin
    lg_c  = (LG_W'(UB) << QF) - LG_W'({sq_k_r[QF], sq_frac_r[QF]});
    lgp_c = lg_c * (LG_W + 30)'(LN2_Q30);
  end

  always_ff @(posedge clk) begin
    rt_rad_r[0]  <= (2*T_W)'({lgp_c[29 +: Y_W], {QF{1'b0}}});
    rt_rem_r[0]  <= '0;
    rt_root_r[0] <= '0;
  end

  // restoring square root, one result bit per stage
  for (genvar j = 0; j < T_W; j++) begin : g_rt
    logic [T_W+1:0] sh;
    logic [T_W+1:0] trial;
    logic           ge;

    always_comb begin
      sh    = {rt_rem_r[j][T_W-1:0], rt_rad_r[j][2*T_W-1 -: 2]};
      trial = {rt_root_r[j], 2'b01};
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      rt_rem_r[j+1]  <= ge ? (sh - trial) : sh;
      rt_root_r[j+1] <= {rt_root_r[j][T_W-2:0], ge};
      rt_rad_r[j+1]  <= rt_rad_r[j] << 2;
    end
  end

  // ---------------------------------------------------------------------------
  // numerator and denominator polynomials (Horner, one multiply per stage)
  // ---------------------------------------------------------------------------
  logic [T_W-1:0]   t0_c;
  logic [2*T_W-1:0] pa1_c, pb1_c, pa2_c, pb2_c;
  logic [2*T_W:0]   pb3_c;
  logic [T_W-1:0]   ac_c, bd_c;
  logic [T_W:0]     bd2_c;

  logic [T_W-1:0]   a1_r, b1_r, t1_r;
  logic [T_W+1:0]   a2_r;
  logic [T_W-1:0]   b2_r, t2_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-2:0] b3_r;
  logic [T_W-1:0]   t3_r;

  assign t0_c = rt_root_r[T_W];

  always_comb begin
    pa1_c = C2T * t0_c;
    pb1_c = D2T * t0_c;
    ac_c  = a1_r + C1T;
    bd_c  = b1_r + D1T;
    pa2_c = ac_c * t1_r;
    pb2_c = bd_c * t1_r;
    bd2_c = (T_W + 1)'(b2_r) + (T_W + 1)'(D0T);
    pb3_c = bd2_c * (T_W + 1)'(t2_r);
  end

  always_ff @(posedge clk) begin
    a1_r  <= pa1_c[QF +: T_W];
    b1_r  <= pb1_c[QF +: T_W];
    t1_r  <= t0_c;
    a2_r  <= pa2_c[QF +: T_W + 2];
    b2_r  <= pb2_c[QF +: T_W];
    t2_r  <= t1_r;
    num_r <= NUM_W'(a2_r) + NUM_W'(C0T);
    b3_r  <= pb3_c[QF +: DEN_W - 1];
    t3_r  <= t2_r;
  end

  // ---------------------------------------------------------------------------
  // q = (num << QF) / den, restoring, one quotient bit per stage
  // ---------------------------------------------------------------------------
  logic [DEN_W:0]   dv_rem_r [0:Q_W];
  logic [DEN_W-1:0] dv_den_r [0:Q_W];
  logic [Q_W-1:0]   dv_lo_r  [0:Q_W];
  logic [Q_W-1:0]   dv_q_r   [0:Q_W];
  logic [T_W-1:0]   dv_t_r   [0:Q_W];

  // the top bits of num << QF are below den, so no quotient bits are lost
  always_ff @(posedge clk) begin
    dv_rem_r[0] <= (DEN_W + 1)'(num_r[NUM_W-1 -: QF]);
    dv_den_r[0] <= DEN_W'(b3_r) + (DEN_W'(1) << QF);
    dv_lo_r[0]  <= {num_r[NUM_W-QF-1:0], {QF{1'b0}}};
    dv_q_r[0]   <= '0;
    dv_t_r[0]   <= t3_r;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_dv
    logic [DEN_W:0] sh;
    logic           ge;

    always_comb begin
      sh = {dv_rem_r[j][DEN_W-1:0], dv_lo_r[j][Q_W-1]};
      ge = (sh >= {1'b0, dv_den_r[j]});
    end

    always_ff @(posedge clk) begin
      dv_rem_r[j+1] <= ge ? (sh - {1'b0, dv_den_r[j]}) : sh;
      dv_den_r[j+1] <= dv_den_r[j];
      dv_lo_r[j+1]  <= dv_lo_r[j] << 1;
      dv_q_r[j+1]   <= {dv_q_r[j][Q_W-2:0], ge};
      dv_t_r[j+1]   <= dv_t_r[j];
    end
  end

  // ---------------------------------------------------------------------------
  // z = t - q, sign flipped for the lower half; then scale and offset
  // ---------------------------------------------------------------------------
  logic signed [Z_W-1:0] z_c;
  logic                  zneg_c;
  logic [Q_W-1:0]        zmag_r;
  logic                  zneg_r;
  logic [P_W-1:0]        prod_r;
  logic                  zneg2_r;

  always_comb begin
    z_c    = $signed(Z_W'(dv_t_r[Q_W])) - $signed(Z_W'(dv_q_r[Q_W]));
    zneg_c = (z_c != '0) && ((z_c < 0) != low_r[S_DV]);
  end

  always_ff @(posedge clk) begin
    zmag_r  <= (z_c < 0) ? Q_W'(-z_c) : Q_W'(z_c);
    zneg_r  <= zneg_c;
    prod_r  <= zmag_r * P_W'(std_r);
    zneg2_r <= zneg_r;
  end

  logic [P_W:0]            rsum_c;
  logic [MAG_W-1:0]        mag_c;
  logic signed [TOT_W-1:0] tot_c;
  logic signed [TOT_W-1:0] smag_c;

  always_comb begin
    rsum_c = (P_W + 1)'(prod_r) + ((P_W + 1)'(1) << (QF - 1));
    mag_c  = rsum_c[QF +: MAG_W];
    smag_c = zneg2_r ? -$signed(TOT_W'(mag_c)) : $signed(TOT_W'(mag_c));
    tot_c  = TOT_W'($signed(mean_r)) + smag_c;
  end

  logic signed [31:0] samp_r;
  logic               sat_r;

  always_ff @(posedge clk) begin
    if (tot_c > SMAX) begin
      samp_r <= 32'sh7fff_ffff;
      sat_r  <= 1'b1;
    end else if (tot_c < SMIN) begin
      samp_r <= 32'sh8000_0000;
      sat_r  <= 1'b1;
    end else begin
      samp_r <= tot_c[31:0];
      sat_r  <= 1'b0;
    end
  end

  assign out_valid        = vld_r[LAT-1];
  assign out_sample_value = samp_r;
  assign out_saturated    = sat_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_rt_rem : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_RT] |-> (rt_rem_r[T_W] <= {1'b0, rt_root_r[T_W], 1'b0}))
    else $error("square root remainder exceeds 2*root");

  a_dv_rem : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_DV] |-> (dv_rem_r[Q_W] < {1'b0, dv_den_r[Q_W]}))
    else $error("divider remainder not below denominator");

  a_sat : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_sample_value == 32'sh7fff_ffff || out_sample_value == 32'sh8000_0000))
    else $error("saturation flag without clipped sample");

  a_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_Z] && zmag_r == '0) |-> !zneg_r)
    else $error("zero magnitude marked negative");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import gics_pkg::*;

  // pipeline depth with the default 32-bit word
  localparam int PIPE_LAT  = 105;
  // cycles with no transaction of any kind before the run is abandoned
  localparam int STALL_LIM = 2000;
  localparam int RAND_ITEMS_PER_PHASE = 240;

  // Q28 working format and the Q28 / Q30 constants, written out independently
  localparam int unsigned WQ = 28;
  localparam bit [63:0] LN2_W = 64'd744261118;
  localparam bit [63:0] K_C0 = 64'd675253953;
  localparam bit [63:0] K_C1 = 64'd215514211;
  localparam bit [63:0] K_C2 = 64'd2772401;
  localparam bit [63:0] K_D0 = 64'd384611100;
  localparam bit [63:0] K_D1 = 64'd50806510;
  localparam bit [63:0] K_D2 = 64'd351114;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               sat;
  } gauss_res_t;

  // sample predictor plus the queue of samples still owed by the pipeline
  class sample_scoreboard;
    bit [31:0]  mean_q16;
    bit [31:0]  sigma_q16;
    gauss_res_t owed[$];
    int         n_err;

    function new();
      mean_q16  = MEAN_RST;
      sigma_q16 = STD_RST;
      n_err     = 0;
    endfunction

    function void set_reg(logic idx, bit [31:0] val);
      if (idx == CFG_MEAN) mean_q16 = val;
      else sigma_q16 = val;
    endfunction

    // log2 in Q28: exact integer part, fraction by repeated squaring of a Q30 mantissa
    function bit [63:0] log2_fix(bit [63:0] x);
      int unsigned k;
      bit [63:0]   m;
      bit [63:0]   frac;
      k = 0;
      frac = 0;
      while (k < 63 && (x >> (k + 1)) != 0) k++;
      m = (k >= 30) ? (x >> (k - 30)) : (x << (30 - k));
      for (int i = 0; i < WQ; i++) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          frac[WQ-1-i] = 1'b1;
        end
      end
      return (64'(k) << WQ) + frac;
    endfunction

    function bit [63:0] sqrt_fix(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function gauss_res_t predict(bit [31:0] u_in);
      bit [63:0]          u, x, lg, y, t, num, den, q, zmag, mag;
      bit                 lower;
      longint             z, total;
      gauss_res_t         r;
      u = {32'd0, u_in};
      if (u == 0) u = 1;            // zero clamps to the smallest step
      lower = (u < 64'h8000_0000);  // exact half goes to the upper side
      x = lower ? u : (64'h1_0000_0000 - u);
      lg  = (64'd32 << WQ) - log2_fix(x);
      y   = (lg * LN2_W) >> 29;
      t   = sqrt_fix(y << WQ);
      num = ((((K_C2 * t) >> WQ) + K_C1) * t >> WQ) + K_C0;
      den = ((((((K_D2 * t) >> WQ) + K_D1) * t >> WQ) + K_D0) * t >> WQ) + (64'd1 << WQ);
      q   = (num << WQ) / den;
      z = longint'(t) - longint'(q);
      if (lower) z = -z;
      zmag = (z < 0) ? 64'(-z) : 64'(z);
      mag  = (zmag * {32'd0, sigma_q16} + (64'd1 << (WQ - 1))) >> WQ;
      total = longint'(signed'(mean_q16)) + ((z < 0) ? -longint'(mag) : longint'(mag));
      r.sat = 1'b0;
      if (total > 64'sd2147483647) begin
        total = 64'sd2147483647;
        r.sat = 1'b1;
      end else if (total < -64'sd2147483648) begin
        total = -64'sd2147483648;
        r.sat = 1'b1;
      end
      r.sample = total[31:0];
      return r;
    endfunction

    function void note_input(bit [31:0] u);
      owed.push_back(predict(u));
    endfunction

    function void check_result(logic signed [31:0] val, logic sat);
      gauss_res_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected sample %h sat %b", $time, val, sat);
        n_err++;
        return;
      end
      e = owed.pop_front();
      if (val !== e.sample) begin
        $display("%0t: sample mismatch, expected %h actual %h", $time, e.sample, val);
        n_err++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated mismatch, expected %b actual %b", $time, e.sat, sat);
        n_err++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [31:0]        in_uniform_fraction;
  logic               out_valid;
  logic signed [31:0] out_sample_value;
  logic               out_saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [31:0]        cfg_data;

  sample_scoreboard sb = new();
  bit  gaps_on;     // sender idling enabled
  int  quiet_cycles;

  gaussian_inverse_cdf_sampler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_uniform_fraction(in_uniform_fraction),
    .out_valid(out_valid), .out_sample_value(out_sample_value),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: samples are strobed for one cycle and cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_sample_value, out_saturated);
  end

  // watchdog: any transaction on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIM) begin
        $display("gaussian_inverse_cdf_sampler test failed");
        $finish;
      end
    end
  end

  // one input transaction; start is left high so back-to-back words need no toggle
  task automatic send_word(bit [31:0] u);
    while (gaps_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      in_uniform_fraction <= $urandom();
      @(posedge clk);
    end
    start <= 1'b1;
    in_uniform_fraction <= u;
    do @(posedge clk); while (busy);
    sb.note_input(u);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // valid is left high so that back-to-back writes need no toggle; the caller drops it
  task automatic write_reg(logic idx, bit [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // mix of plain uniform words, deep tails on both sides and words near the midpoint
  function automatic bit [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom() >> $urandom_range(31);
      1: return ~($urandom() >> $urandom_range(31));
      2: return 32'h8000_0000 + $urandom_range(64) - 32;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(bit [31:0] m, bit [31:0] s, bit hold_mid);
    bit [31:0] corner[$];
    corner = '{32'h0, 32'h1, 32'h2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
               32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h4000_0000, 32'hC000_0000,
               32'h0001_0000, 32'hFFFF_0000, 32'hAAAA_AAAA, 32'h5555_5555};
    drain();
    write_reg(CFG_MEAN, m);
    write_reg(CFG_STD, s);
    cfg_valid <= 1'b0;
    foreach (corner[i]) send_word(corner[i]);
    for (int i = 0; i < RAND_ITEMS_PER_PHASE; i++) begin
      // a run of back-to-back words in the middle of each phase
      gaps_on = !(i >= 80 && i < 160);
      if (hold_mid && i == RAND_ITEMS_PER_PHASE / 2) drain();
      send_word(rand_word());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_uniform_fraction = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MEAN;
    cfg_data = '0;
    gaps_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values first, then the register extremes and a couple of random pairs
    run_phase(MEAN_RST, STD_RST, 1'b1);
    run_phase(32'h0, 32'h0, 1'b0);
    run_phase(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    run_phase(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    run_phase($urandom(), $urandom(), 1'b0);
    run_phase($urandom() >> 8, $urandom() >> 12, 1'b0);

    drain();
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (sb.n_err == 0 && sb.owed.size() == 0) begin
      $display("gaussian_inverse_cdf_sampler test passed");
    end else begin
      $display("gaussian_inverse_cdf_sampler test failed");
    end
    $finish;
  end

endmodule
